// File: sv/lr1pe_pkg.sv
// Shared constants, codes and state type for the LR(1) parse engine.
`timescale 1ns / 1ps
package lr1pe_pkg;
	localparam int DEF_MAX_STATES      = 64;
	localparam int DEF_SYMBOL_BITS     = 7;
	localparam int DEF_MAX_RULES       = 64;
	localparam int DEF_MAX_RULE_LENGTH = 16;
	localparam int DEF_STACK_DEPTH     = 256;

	localparam int SYM_W    = 7;
	localparam int NUM_W    = 6;
	localparam int LEN_W    = 4;
	localparam int KIND_W   = 2;
	localparam int ACT_W    = 3;
	localparam int REASON_W = 3;
	localparam int ENTRY_W  = KIND_W + NUM_W;
	localparam int HDR_W    = SYM_W + LEN_W;
	localparam int STK_W    = SYM_W + NUM_W;
	localparam logic [SYM_W-1:0] END_SYMBOL_RST = 7'd36;
	localparam logic [NUM_W-1:0] START_STATE    = 6'd1;
	localparam logic [NUM_W-1:0] ACCEPT_RULE    = 6'd1;

	typedef enum logic [ACT_W-1:0] {
		ACT_LOAD_ENTRY = 3'd0,
		ACT_LOAD_HDR   = 3'd1,
		ACT_LOAD_SYM   = 3'd2,
		ACT_START      = 3'd3,
		ACT_TOKEN      = 3'd4
	} act_t;

	typedef enum logic [KIND_W-1:0] {
		K_EMPTY  = 2'd0,
		K_SHIFT  = 2'd1,
		K_GOTO   = 2'd2,
		K_REDUCE = 2'd3
	} kind_t;

	typedef enum logic [REASON_W-1:0] {
		RS_ACCEPT    = 3'd0,
		RS_NO_ENTRY  = 3'd1,
		RS_MISMATCH  = 3'd2,
		RS_BAD_GOTO  = 3'd3,
		RS_OVERFLOW  = 3'd4,
		RS_NO_ACCEPT = 3'd5
	} reason_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_TEVAL,
		ST_RHDR,
		ST_CRD,
		ST_CCMP,
		ST_POP,
		ST_TOPRD,
		ST_GEVAL,
		ST_FIN
	} state_t;
endpackage

// File: sv/lr1pe_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
module lr1pe_ram #(
	parameter int WIDTH  = 8,
	parameter int ADDR_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem [1 << ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// File: sv/lr1_parse_engine_core.sv
// Top level of the table-driven LR(1) parse engine.
//
// Input stream: s_axis_tuser carries the action code, s_axis_tdata the
// item fields. Loads write the action table, rule headers and rule symbols.
// A start item opens a word with the stack at state 1. A token runs table
// actions on one shared lookup sequencer: a lookup reads the action table
// (LOOK, TEVAL); a reduce reads the rule header (RHDR), checks each
// right-side symbol (CRD, CCMP), pops (POP), reads the new top (TOPRD) and
// takes its goto (GEVAL); a shift ends the token. Latency grows per reduce.
// A token that ends the word (accept or reject) puts one verdict on the
// master stream; the engine keeps taking items while that verdict waits,
// and stalls only when a second verdict is ready before the first left.
// After reset the action table is cleared, one entry per cycle, all
// 2^(clog2(MAX_STATES)+SYMBOL_BITS) entries (8192 by default); no item is
// taken meanwhile. The APB register end_symbol may be written at any time.
`timescale 1ns / 1ps
module lr1_parse_engine_core
	import lr1pe_pkg::*;
#(
	parameter int MAX_STATES      = DEF_MAX_STATES,
	parameter int SYMBOL_BITS     = DEF_SYMBOL_BITS,
	parameter int MAX_RULES       = DEF_MAX_RULES,
	parameter int MAX_RULE_LENGTH = DEF_MAX_RULE_LENGTH,
	parameter int STACK_DEPTH     = DEF_STACK_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// state_number[5:0] symbol[12:6] entry_kind[14:13] entry_number[20:15]
	// rule_number[26:21] rule_left[33:27] rule_length[37:34] rhs_position[41:38]
	input  logic [47:0] s_axis_tdata,
	// action[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// accepted[0] reason_code[3:1]
	output logic [7:0]  m_axis_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int STW    = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
	localparam int TW     = STW + SYMBOL_BITS;
	localparam int RW     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int PW     = (MAX_RULE_LENGTH > 1) ? $clog2(MAX_RULE_LENGTH) : 1;
	localparam int AW     = $clog2(STACK_DEPTH);
	localparam int SPW    = $clog2(STACK_DEPTH + 1);
	localparam int LIMIT  = 2 * (STACK_DEPTH + MAX_STATES);
	localparam int CW     = $clog2(LIMIT + 1);

	// input fields
	logic [NUM_W-1:0]  in_st;
	logic [SYM_W-1:0]  in_sym;
	logic [KIND_W-1:0] in_kind;
	logic [NUM_W-1:0]  in_num;
	logic [NUM_W-1:0]  in_rule;
	logic [SYM_W-1:0]  in_left;
	logic [LEN_W-1:0]  in_len;
	logic [LEN_W-1:0]  in_pos;
	act_t              in_act;

	assign in_st   = s_axis_tdata[5:0];
	assign in_sym  = s_axis_tdata[12:6];
	assign in_kind = s_axis_tdata[14:13];
	assign in_num  = s_axis_tdata[20:15];
	assign in_rule = s_axis_tdata[26:21];
	assign in_left = s_axis_tdata[33:27];
	assign in_len  = s_axis_tdata[37:34];
	assign in_pos  = s_axis_tdata[41:38];
	assign in_act  = act_t'(s_axis_tuser);

	state_t            state_q, state_d;
	logic [SYM_W-1:0]  end_q;
	logic [SPW-1:0]    sp_q, base_q;
	logic [NUM_W-1:0]  top_q, rule_q;
	logic [SYM_W-1:0]  tok_q, left_q;
	logic [LEN_W-1:0]  len_q, i_q;
	logic [CW-1:0]     cnt_q;
	logic              fin_q, done_q;
	logic [TW-1:0]     clr_q;
	reason_t           reason_q, reason_d;
	logic              out_acc_q;
	reason_t           out_rs_q;
	logic              out_vld_q;

	// memory ports
	logic              tbl_we;
	logic [TW-1:0]     tbl_waddr, tbl_raddr;
	logic [ENTRY_W-1:0] tbl_wdata, tbl_rdata;
	logic              hdr_we;
	logic [RW-1:0]     hdr_waddr, hdr_raddr;
	logic [HDR_W-1:0]  hdr_rdata;
	logic              rs_we;
	logic [RW+PW-1:0]  rs_waddr, rs_raddr;
	logic [SYM_W-1:0]  rs_rdata;
	logic              stk_we;
	logic [AW-1:0]     stk_waddr, stk_raddr;
	logic [STK_W-1:0]  stk_wdata, stk_rdata;

	logic accept_in;
	logic tok_ok, left_ok, top_ok, sp_full;
	logic [ENTRY_W-1:0] look_e, goto_e;
	kind_t look_k, goto_k;
	logic [NUM_W-1:0] look_n, goto_n;
	logic [LEN_W-1:0] h_len;
	logic [SYM_W-1:0] h_left;
	logic h_bad, cmp_eq, cmp_last, out_free;

	assign pready = 1'b1;
	assign prdata = {{(32-SYM_W){1'b0}}, end_q};

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept_in     = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_vld_q || m_axis_tready;

	assign top_ok  = 32'(top_q) < MAX_STATES;
	assign tok_ok  = 32'(tok_q) < (1 << SYMBOL_BITS);
	assign left_ok = 32'(left_q) < (1 << SYMBOL_BITS);
	assign sp_full = 32'(sp_q) >= STACK_DEPTH;
	assign look_e  = (top_ok && tok_ok) ? tbl_rdata : '0;
	assign goto_e  = (top_ok && left_ok) ? tbl_rdata : '0;
	assign look_k  = kind_t'(look_e[ENTRY_W-1 -: KIND_W]);
	assign look_n  = look_e[NUM_W-1:0];
	assign goto_k  = kind_t'(goto_e[ENTRY_W-1 -: KIND_W]);
	assign goto_n  = goto_e[NUM_W-1:0];
	assign h_len   = hdr_rdata[LEN_W-1:0];
	assign h_left  = hdr_rdata[HDR_W-1 -: SYM_W];
	assign h_bad   = (32'(h_len) > MAX_RULE_LENGTH) || ((32'(sp_q) - 32'd1) < 32'(h_len));
	assign cmp_eq  = stk_rdata[STK_W-1 -: SYM_W] == rs_rdata;
	assign cmp_last = (i_q + LEN_W'(1)) == len_q;

	lr1pe_ram #(.WIDTH(ENTRY_W), .ADDR_W(TW)) u_tbl (
		.clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
		.raddr(tbl_raddr), .rdata(tbl_rdata)
	);
	lr1pe_ram #(.WIDTH(HDR_W), .ADDR_W(RW)) u_hdr (
		.clk(clk), .we(hdr_we), .waddr(hdr_waddr), .wdata({in_left, in_len}),
		.raddr(hdr_raddr), .rdata(hdr_rdata)
	);
	lr1pe_ram #(.WIDTH(SYM_W), .ADDR_W(RW + PW)) u_rsym (
		.clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(in_sym),
		.raddr(rs_raddr), .rdata(rs_rdata)
	);
	lr1pe_ram #(.WIDTH(STK_W), .ADDR_W(AW)) u_stk (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	// next state
	always_comb begin
		state_d  = state_q;
		reason_d = RS_ACCEPT;
		unique case (state_q)
			ST_CLEAR: begin
				if (&clr_q) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept_in && in_act == ACT_TOKEN && !done_q && sp_q != '0)
					state_d = ST_LOOK;
			end
			ST_LOOK: begin
				if (32'(cnt_q) == LIMIT) begin
					state_d  = ST_FIN;
					reason_d = RS_NO_ACCEPT;
				end else begin
					state_d = ST_TEVAL;
				end
			end
			ST_TEVAL: begin
				state_d = ST_FIN;
				case (look_k)
					K_EMPTY: reason_d = RS_NO_ENTRY;
					K_GOTO:  reason_d = RS_BAD_GOTO;
					K_SHIFT: begin
						if (tok_q == end_q) reason_d = RS_NO_ACCEPT;
						else if (sp_full) reason_d = RS_OVERFLOW;
						else state_d = ST_IDLE;
					end
					default: begin
						if (32'(look_n) >= MAX_RULES) reason_d = RS_MISMATCH;
						else state_d = ST_RHDR;
					end
				endcase
			end
			ST_RHDR: begin
				if (h_bad) begin
					state_d  = ST_FIN;
					reason_d = RS_MISMATCH;
				end else if (h_len == '0) begin
					state_d = ST_POP;
				end else begin
					state_d = ST_CRD;
				end
			end
			ST_CRD: state_d = ST_CCMP;
			ST_CCMP: begin
				if (!cmp_eq) begin
					state_d  = ST_FIN;
					reason_d = RS_MISMATCH;
				end else if (cmp_last) begin
					state_d = ST_POP;
				end else begin
					state_d = ST_CRD;
				end
			end
			ST_POP: begin
				if (fin_q) begin
					state_d  = ST_FIN;
					reason_d = RS_ACCEPT;
				end else begin
					state_d = ST_TOPRD;
				end
			end
			ST_TOPRD: state_d = ST_GEVAL;
			ST_GEVAL: begin
				state_d = ST_FIN;
				if (goto_k == K_EMPTY) reason_d = RS_NO_ENTRY;
				else if (goto_k != K_GOTO) reason_d = RS_BAD_GOTO;
				else if (sp_full) reason_d = RS_OVERFLOW;
				else state_d = ST_LOOK;
			end
			ST_FIN: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = {STW'(in_st), SYMBOL_BITS'(in_sym)};
		tbl_wdata = {in_kind, in_num};
		tbl_raddr = {STW'(top_q), SYMBOL_BITS'(tok_q)};
		hdr_we    = accept_in && in_act == ACT_LOAD_HDR && 32'(in_rule) < MAX_RULES;
		hdr_waddr = RW'(in_rule);
		hdr_raddr = RW'(look_n);
		rs_we     = accept_in && in_act == ACT_LOAD_SYM && 32'(in_rule) < MAX_RULES
			&& 32'(in_pos) < MAX_RULE_LENGTH;
		rs_waddr  = {RW'(in_rule), PW'(in_pos)};
		rs_raddr  = {RW'(rule_q), PW'(i_q)};
		stk_we    = 1'b0;
		stk_waddr = AW'(sp_q);
		stk_wdata = {tok_q, look_n};
		stk_raddr = AW'(base_q + SPW'(i_q));
		unique case (state_q)
			ST_CLEAR: begin
				tbl_we    = 1'b1;
				tbl_waddr = clr_q;
				tbl_wdata = '0;
			end
			ST_IDLE: begin
				tbl_we = accept_in && in_act == ACT_LOAD_ENTRY
					&& 32'(in_st) < MAX_STATES && 32'(in_sym) < (1 << SYMBOL_BITS);
				if (accept_in && in_act == ACT_START) begin
					stk_we    = 1'b1;
					stk_waddr = '0;
					stk_wdata = {{SYM_W{1'b0}}, START_STATE};
				end
			end
			ST_TEVAL: begin
				stk_we = look_k == K_SHIFT && tok_q != end_q && !sp_full;
			end
			ST_POP: stk_raddr = AW'(base_q - SPW'(1));
			ST_TOPRD: tbl_raddr = {STW'(stk_rdata[NUM_W-1:0]), SYMBOL_BITS'(left_q)};
			ST_GEVAL: begin
				stk_we    = goto_k == K_GOTO && !sp_full;
				stk_wdata = {left_q, goto_n};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			end_q     <= END_SYMBOL_RST;
			sp_q      <= '0;
			base_q    <= '0;
			top_q     <= '0;
			rule_q    <= '0;
			tok_q     <= '0;
			left_q    <= '0;
			len_q     <= '0;
			i_q       <= '0;
			fin_q     <= 1'b0;
			done_q    <= 1'b1;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
			out_acc_q <= 1'b0;
			out_rs_q  <= RS_ACCEPT;
			reason_q  <= RS_ACCEPT;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite && !paddr[2]) end_q <= pwdata[SYM_W-1:0];
			if (state_q == ST_FIN && out_free) out_vld_q <= 1'b1;
			else if (m_axis_tready) out_vld_q <= 1'b0;
			if (state_d == ST_FIN && state_q != ST_FIN) reason_q <= reason_d;
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + TW'(1);
				ST_IDLE: begin
					if (accept_in && in_act == ACT_START) begin
						sp_q   <= SPW'(1);
						top_q  <= START_STATE;
						done_q <= 1'b0;
					end
					tok_q <= in_sym;
					cnt_q <= '0;
				end
				ST_TEVAL: begin
					if (look_k == K_SHIFT && state_d == ST_IDLE) begin
						sp_q  <= sp_q + SPW'(1);
						top_q <= look_n;
					end
					cnt_q  <= cnt_q + CW'(1);
					rule_q <= look_n;
					fin_q  <= look_n == ACCEPT_RULE && tok_q == end_q;
				end
				ST_RHDR: begin
					len_q  <= h_len;
					left_q <= h_left;
					base_q <= sp_q - SPW'(h_len);
					i_q    <= '0;
				end
				ST_CCMP: i_q <= i_q + LEN_W'(1);
				ST_POP: sp_q <= base_q;
				ST_TOPRD: top_q <= stk_rdata[NUM_W-1:0];
				ST_GEVAL: begin
					if (state_d == ST_LOOK) begin
						sp_q  <= sp_q + SPW'(1);
						top_q <= goto_n;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_acc_q <= reason_q == RS_ACCEPT;
						out_rs_q  <= reason_q;
						done_q    <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {4'd0, out_rs_q, out_acc_q};
endmodule
